// ===== sv/hrpt_pkg.sv =====
package hrpt_pkg;

  localparam int unsigned AddrW = 64;
  localparam int unsigned TableEntriesDef = 16;

  // tdata layout of a request: address, size, writable, zero fill to bytes
  localparam int unsigned ReqDataW = 136;
  localparam int unsigned RspDataW = 8;

  typedef enum logic [1:0] {
    REQ_PUBLISH  = 2'd0,
    REQ_REVOKE   = 2'd1,
    REQ_VALIDATE = 2'd2
  } req_type_e;

  // request as it walks down the cell chain
  typedef struct packed {
    logic             vld;
    req_type_e        kind;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] lim;        // exclusive end of the range
    logic             wr;
    logic             rok;        // range checks passed (revoke: address nonzero)
    logic             hit;        // overlap / match / containment seen so far
    logic             free_found; // a free slot was seen upstream
  } req_t;

  // table write broadcast after a successful publish
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] lim;
    logic             wok;
  } wr_t;

endpackage

// ===== sv/hrpt_cell.sv =====
module hrpt_cell import hrpt_pkg::*; #(
  parameter int unsigned   IdxW    = 4,
  parameter logic [IdxW-1:0] CellIdx = '0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  req_t            req_i,
  input  logic [IdxW-1:0] fidx_i,
  input  wr_t             cmt_i,
  input  logic [IdxW-1:0] cidx_i,
  output req_t            req_o,
  output logic [IdxW-1:0] fidx_o
);

  logic             valid_q, valid_d;
  logic [AddrW-1:0] begin_q, end_q;
  logic             wok_q;
  req_t             req_q, req_d;
  logic [IdxW-1:0]  fidx_q, fidx_d;

  logic overlap, contain, match, cmt_hit;

  assign overlap = valid_q && (req_i.addr < end_q) && (begin_q < req_i.lim);
  assign contain = valid_q && (begin_q <= req_i.addr) && (req_i.lim <= end_q) &&
                   (!req_i.wr || wok_q);
  assign match   = valid_q && (begin_q == req_i.addr);
  assign cmt_hit = cmt_i.en && (cidx_i == CellIdx);

  always_comb begin
    req_d   = req_i;
    fidx_d  = fidx_i;
    valid_d = valid_q;
    if (cmt_hit) begin
      valid_d = 1'b1;
    end
    if (req_i.vld) begin
      case (req_i.kind)
        REQ_PUBLISH: begin
          if (overlap) begin
            req_d.hit = 1'b1;
          end
          if (!valid_q && !req_i.free_found) begin
            req_d.free_found = 1'b1;
            fidx_d           = CellIdx;
          end
        end
        REQ_REVOKE: begin
          // first matching entry upstream-most wins
          if (req_i.rok && !req_i.hit && match) begin
            req_d.hit = 1'b1;
            valid_d   = 1'b0;
          end
        end
        REQ_VALIDATE: begin
          if (contain) begin
            req_d.hit = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      req_q.vld <= 1'b0;
    end else begin
      valid_q <= valid_d;
      req_q   <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fidx_q <= fidx_d;
    if (cmt_hit) begin
      begin_q <= cmt_i.addr;
      end_q   <= cmt_i.lim;
      wok_q   <= cmt_i.wok;
    end
  end

  assign req_o  = req_q;
  assign fidx_o = fidx_q;

endmodule

// ===== sv/host_range_permission_table.sv =====
// Path: an accepted request is registered at the head, in each cell of the
//   chain in turn, then in the holding and output registers. One request at a
//   time: the next enters once the last result moves into the output register.
// Reset: asynchronous, active low; empties the table (all entries invalid)
//   and drops any request in flight. Entry contents are not cleared.
module host_range_permission_table import hrpt_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ReqDataW-1:0] s_axis_tdata,  // [63:0] address, [127:64] size,
                                             // [128] writable, rest zero
  input  logic [1:0]          s_axis_tuser,  // [1:0] req_type
  // response channel
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [RspDataW-1:0] m_axis_tdata   // [0] ok, rest zero
);

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  // ---------------------------------------------------------------------------
  // Request intake. One request in flight: busy from accept until its result
  // moves into the output register.
  // ---------------------------------------------------------------------------
  logic busy_q, busy_d;
  logic in_acc;

  assign s_axis_tready = !busy_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  logic [AddrW-1:0] in_addr, in_size;
  logic [AddrW:0]   in_sum;
  req_type_e        in_kind;
  req_t             head_q, head_d;

  assign in_addr = s_axis_tdata[AddrW-1:0];
  assign in_size = s_axis_tdata[2*AddrW-1:AddrW];
  assign in_kind = req_type_e'(s_axis_tuser);
  // carry out means the end would pass the top of the address space
  assign in_sum  = {1'b0, in_addr} + {1'b0, in_size};

  always_comb begin
    head_d            = '0;
    head_d.vld        = in_acc;
    head_d.kind       = in_kind;
    head_d.addr       = in_addr;
    head_d.lim        = in_sum[AddrW-1:0];
    head_d.wr         = s_axis_tdata[2*AddrW];
    head_d.hit        = 1'b0;
    head_d.free_found = 1'b0;
    if (in_kind == REQ_REVOKE) begin
      head_d.rok = (in_addr != '0);
    end else begin
      head_d.rok = (in_addr != '0) && (in_size != '0) && !in_sum[AddrW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q.vld <= 1'b0;
    end else begin
      head_q <= head_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain: one cell per table entry, request steps one cell per cycle.
  // ---------------------------------------------------------------------------
  req_t            chain   [TableEntries+1];
  logic [IdxW-1:0] fchain  [TableEntries+1];
  wr_t             cmt;
  logic [IdxW-1:0] cmt_idx;

  assign chain[0]  = head_q;
  assign fchain[0] = '0;

  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    hrpt_cell #(
      .IdxW    (IdxW),
      .CellIdx (IdxW'(g))
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (chain[g]),
      .fidx_i (fchain[g]),
      .cmt_i  (cmt),
      .cidx_i (cmt_idx),
      .req_o  (chain[g+1]),
      .fidx_o (fchain[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Chain tail: final verdict and publish write-back into the free slot.
  // ---------------------------------------------------------------------------
  req_t tail;
  logic tail_ok;

  assign tail = chain[TableEntries];

  always_comb begin
    case (tail.kind)
      REQ_PUBLISH:  tail_ok = tail.rok && !tail.hit && tail.free_found;
      REQ_REVOKE:   tail_ok = tail.rok && tail.hit;
      REQ_VALIDATE: tail_ok = tail.rok && tail.hit;
      default:      tail_ok = 1'b0;
    endcase
  end

  assign cmt.en   = tail.vld && (tail.kind == REQ_PUBLISH) && tail_ok;
  assign cmt.addr = tail.addr;
  assign cmt.lim  = tail.lim;
  assign cmt.wok  = tail.wr;
  assign cmt_idx  = fchain[TableEntries];

  // ---------------------------------------------------------------------------
  // Result holding register and output register.
  // ---------------------------------------------------------------------------
  logic pend_vld_q, pend_vld_d, pend_ok_q, pend_ok_d;
  logic out_vld_q, out_vld_d, out_ok_q, out_ok_d;
  logic pend_mv;

  assign pend_mv = pend_vld_q && (!out_vld_q || m_axis_tready);

  always_comb begin
    pend_vld_d = pend_vld_q;
    pend_ok_d  = pend_ok_q;
    out_vld_d  = out_vld_q;
    out_ok_d   = out_ok_q;
    busy_d     = busy_q;
    if (tail.vld) begin
      pend_vld_d = 1'b1;
      pend_ok_d  = tail_ok;
    end else if (pend_mv) begin
      pend_vld_d = 1'b0;
    end
    if (pend_mv) begin
      out_vld_d = 1'b1;
      out_ok_d  = pend_ok_q;
      busy_d    = 1'b0;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (in_acc) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_ok_q <= pend_ok_d;
    out_ok_q  <= out_ok_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(RspDataW-1){1'b0}}, out_ok_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic [TableEntries:0] chain_vld;
  for (genvar g = 0; g <= TableEntries; g++) begin : g_vld
    assign chain_vld[g] = chain[g].vld;
  end

  // at most one request anywhere between intake and the holding register
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({chain_vld, pend_vld_q}))
    else $error("more than one request in flight");

  // an accepted request enters the chain on the next cycle
  a_head_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> head_q.vld && busy_q)
    else $error("accepted request did not enter the chain");

  // table write only for a publish that found a free slot
  a_cmt_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmt.en |-> tail.vld && tail.free_found && !tail.hit)
    else $error("table write without a free slot");

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import hrpt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TblN = TableEntriesDef;
  localparam logic [AddrW-1:0] AddrTop = '1;
  // tuser code the block has no operation for; must answer ok = 0
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam int unsigned RandomReqs = 1600;
  // Idle phases, by request count: sender 29% / receiver 85% until PhaseB,
  // swapped until PhaseC, no idling after that.
  localparam int unsigned PhaseB = 540;
  localparam int unsigned PhaseC = 1080;
  // sender holds here until every response is back
  localparam int unsigned DrainAt = 700;
  // receiver holds off this long once, while the sender streams freely
  localparam int unsigned StallAt = 1250;
  localparam int unsigned StallLen = 300;
  // cycles with no handshake on either side before giving up
  localparam int unsigned WatchdogLimit = 3000;

  typedef struct packed {
    logic [1:0]       kind;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] size;
    logic             wr;
  } perm_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [RspDataW-1:0] m_axis_tdata;

  logic      req_valid = 1'b0;
  perm_req_t cur_req = '0;
  logic      rsp_ready = 1'b0;

  perm_req_t   pending_reqs[$];
  int unsigned n_total = 0;
  int unsigned n_issued = 0;   // requests accepted by the block
  int unsigned n_resp = 0;     // responses accepted from the block
  int unsigned n_fail = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  bit          stall_done = 1'b0;

  // ok bit predicted for each accepted request, indexed by accept order
  bit expected_ok [0:4095];

  // shadow copy of the permission table
  bit               shadow_valid [TblN];
  logic [AddrW-1:0] shadow_begin [TblN];
  logic [AddrW-1:0] shadow_end   [TblN];
  bit               shadow_wok   [TblN];

  // recently published ranges, used to aim revokes and validates at real entries
  logic [AddrW-1:0] recent_begin[$];
  logic [AddrW-1:0] recent_len[$];

  logic [AddrW-1:0] zone_base [3] = '{64'h0, 64'h8000_0000_0000_0000,
                                      64'hFFFF_FFFF_FFFF_F000};

  host_range_permission_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (req_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  ({7'b0, cur_req.wr, cur_req.size, cur_req.addr}),
    .s_axis_tuser  (cur_req.kind),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (rsp_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Applies one request to the shadow table and returns the ok bit.
  function automatic bit permission_grant(perm_req_t r);
    logic [AddrW-1:0] lim;
    bit in_range;
    int slot;
    lim = r.addr + r.size;
    // nonzero address and size, end at most the all-ones address
    in_range = (r.addr != '0) && (r.size != '0) && (r.addr <= AddrTop - r.size);
    slot = -1;
    case (r.kind)
      REQ_PUBLISH: begin
        if (!in_range) return 1'b0;
        for (int i = 0; i < TblN; i++) begin
          if (shadow_valid[i]) begin
            if (r.addr < shadow_end[i] && shadow_begin[i] < lim) return 1'b0;
          end else if (slot < 0) begin
            slot = i;
          end
        end
        if (slot < 0) return 1'b0;   // table full
        shadow_valid[slot] = 1'b1;
        shadow_begin[slot] = r.addr;
        shadow_end[slot]   = lim;
        shadow_wok[slot]   = r.wr;
        return 1'b1;
      end
      REQ_REVOKE: begin
        if (r.addr == '0) return 1'b0;
        for (int i = 0; i < TblN; i++) begin
          if (shadow_valid[i] && shadow_begin[i] == r.addr) begin
            shadow_valid[i] = 1'b0;
            return 1'b1;
          end
        end
        return 1'b0;
      end
      REQ_VALIDATE: begin
        if (!in_range) return 1'b0;
        // must fit in one entry; two adjacent entries do not count
        for (int i = 0; i < TblN; i++) begin
          if (shadow_valid[i] && shadow_begin[i] <= r.addr && lim <= shadow_end[i] &&
              (!r.wr || shadow_wok[i])) return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic queue_req(logic [1:0] k, logic [AddrW-1:0] a, logic [AddrW-1:0] s,
                           bit w);
    perm_req_t r;
    r.kind = k;
    r.addr = a;
    r.size = s;
    r.wr   = w;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic note_range(logic [AddrW-1:0] a, logic [AddrW-1:0] s);
    recent_begin.insert(recent_begin.size(), a);
    recent_len.insert(recent_len.size(), s);
    if (recent_begin.size() > 40) begin
      void'(recent_begin.pop_front());
      void'(recent_len.pop_front());
    end
  endtask

  // Request driver: presents the queue head, holds it until accepted and
  // predicts the response at the accepting edge.
  always @(posedge clk_i) begin : req_driver
    int unsigned issued_now;
    int unsigned idle_pct;
    bit go;
    if (rst_ni) begin
      issued_now = n_issued;
      if (req_valid && s_axis_tready) begin
        expected_ok[n_issued] = permission_grant(cur_req);
        issued_now = n_issued + 1;
        n_issued <= issued_now;
      end
      if (!req_valid || s_axis_tready) begin
        idle_pct = (issued_now < PhaseB) ? 29 : (issued_now < PhaseC) ? 85 : 0;
        go = pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct &&
             !(issued_now == DrainAt && n_resp < issued_now);
        if (go) cur_req <= pending_reqs.pop_front();
        req_valid <= go;
      end
    end
  end

  // Response monitor: checks each response against the oldest prediction
  // and drives tready, including one long hold-off.
  always @(posedge clk_i) begin : rsp_monitor
    int unsigned idle_pct;
    if (rst_ni) begin
      if (m_axis_tvalid && rsp_ready) begin
        if (n_resp >= n_issued) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected response: tdata %h", m_axis_tdata);
        end else if (m_axis_tdata !== {7'b0, expected_ok[n_resp]}) begin
          n_fail++;
          if (n_fail <= 10)
            $display("response %0d: ok expected %0b, got tdata %h",
                     n_resp, expected_ok[n_resp], m_axis_tdata);
        end
        n_resp <= n_resp + 1;
      end
      idle_pct = (n_resp < PhaseB) ? 85 : (n_resp < PhaseC) ? 29 : 0;
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp_ready <= 1'b0;
      end else if (!stall_done && n_resp >= StallAt) begin
        stall_done <= 1'b1;
        stall_left <= StallLen;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= $urandom_range(0, 99) >= idle_pct;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((req_valid && s_axis_tready) || (m_axis_tvalid && rsp_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pick;
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] a;
    logic [AddrW-1:0] s;
    logic [AddrW-1:0] off;
    logic [AddrW-1:0] len;

    // directed: range checks, overlap, adjacency, write mark, revoke, top end
    queue_req(REQ_PUBLISH,  64'h0,      64'h10,       1'b1);  // zero address
    queue_req(REQ_PUBLISH,  64'h1000,   64'h0,        1'b1);  // zero size
    queue_req(REQ_PUBLISH,  64'h1000,   64'h100,      1'b1);
    queue_req(REQ_PUBLISH,  64'h10F0,   64'h20,       1'b0);  // overlaps
    queue_req(REQ_PUBLISH,  64'h1100,   64'h100,      1'b0);  // adjacent
    queue_req(REQ_VALIDATE, 64'h1000,   64'h100,      1'b1);
    queue_req(REQ_VALIDATE, 64'h10F0,   64'h20,       1'b0);  // spans two entries
    queue_req(REQ_VALIDATE, 64'h1100,   64'h10,       1'b1);  // read-only entry
    queue_req(REQ_VALIDATE, 64'h11F0,   64'h10,       1'b0);
    queue_req(REQ_VALIDATE, 64'h0,      64'h1,        1'b0);
    queue_req(REQ_VALIDATE, 64'h1000,   64'h0,        1'b0);
    queue_req(REQ_PUBLISH,  AddrTop - 64'd15, 64'd16, 1'b1);  // end would be 2^64
    queue_req(REQ_PUBLISH,  AddrTop - 64'd16, 64'd16, 1'b1);  // end is all-ones
    queue_req(REQ_VALIDATE, AddrTop - 64'd16, 64'd16, 1'b1);
    queue_req(REQ_VALIDATE, AddrTop,    64'h1,        1'b0);  // wraps
    queue_req(REQ_PUBLISH,  AddrTop,    AddrTop,      1'b1);  // wraps
    queue_req(REQ_PUBLISH,  64'h1,      AddrTop - 64'd1, 1'b0);
    queue_req(REQ_REVOKE,   64'h0,      64'h10,       1'b0);
    queue_req(REQ_REVOKE,   64'h1050,   64'h0,        1'b0);  // no such begin
    queue_req(REQ_REVOKE,   64'h1000,   64'h0,        1'b1);
    queue_req(REQ_VALIDATE, 64'h1000,   64'h10,       1'b0);  // revoked
    queue_req(REQ_UNKNOWN,  64'h1100,   64'h10,       1'b1);
    queue_req(REQ_REVOKE,   64'h1100,   AddrTop,      1'b1);
    queue_req(REQ_REVOKE,   AddrTop - 64'd16, 64'h0,  1'b0);

    // random: mostly requests aimed at a few dense zones and at live entries
    while (pending_reqs.size() < 24 + RandomReqs) begin
      pick = $urandom_range(0, 99);
      base = zone_base[$urandom_range(0, 2)];
      if (pick < 12) begin
        // noise: any type, full-width fields
        a = {$urandom, $urandom};
        s = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 255));
        queue_req(2'($urandom_range(0, 3)), a, s, 1'($urandom_range(0, 1)));
      end else if (pick < 15) begin
        // burst of disjoint publishes to run the table full
        base = {$urandom, $urandom} & ~64'hFFFF;
        for (int i = 0; i < TblN + 1; i++) begin
          queue_req(REQ_PUBLISH, base + 64'(i) * 64'h100, 64'h100, 1'($urandom_range(0, 1)));
          note_range(base + 64'(i) * 64'h100, 64'h100);
        end
      end else if (pick < 50) begin
        a = base + (64'($urandom_range(0, 255)) << 4);
        s = $urandom_range(0, 3) == 0 ? 64'($urandom_range(0, 600))
                                      : 64'($urandom_range(1, 32)) << 4;
        queue_req(REQ_PUBLISH, a, s, 1'($urandom_range(0, 1)));
        if (s != '0) note_range(a, s);
      end else if (pick < 70) begin
        if (recent_begin.size() > 0 && $urandom_range(0, 4) != 0) begin
          pick = $urandom_range(0, recent_begin.size() - 1);
          a = recent_begin[pick];
          recent_begin.delete(pick);
          recent_len.delete(pick);
        end else begin
          a = base + (64'($urandom_range(0, 255)) << 4);
        end
        queue_req(REQ_REVOKE, a, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
      end else begin
        if (recent_begin.size() > 0 && $urandom_range(0, 6) != 0) begin
          pick = $urandom_range(0, recent_begin.size() - 1);
          len = recent_len[pick];
          off = 64'($urandom_range(0, 32'(len) - 1));
          a = recent_begin[pick] + off;
          s = 64'($urandom_range(1, 32'(len - off)));
          // sometimes run past the end of the entry
          if ($urandom_range(0, 4) == 0) s = s + 64'($urandom_range(1, 32));
        end else begin
          a = base + 64'($urandom_range(0, 4095));
          s = 64'($urandom_range(0, 512));
        end
        queue_req(REQ_VALIDATE, a, s, 1'($urandom_range(0, 1)));
      end
    end
    n_total = pending_reqs.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (n_issued == n_total && n_resp == n_issued);
    // let any stray response show up
    repeat (2 * (TblN + 3)) @(posedge clk_i);
    if (n_fail == 0 && n_resp == n_issued) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
